// ----- hw/rtl/swhl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swhl_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

  localparam int              WL_W     = 7;
  localparam logic [WL_W-1:0] WL_RESET = 7'd20;

  localparam int IDX_W = 32;

  // controls shared by every cell of the chain
  typedef struct packed {
    logic shift;    // a new bar enters at the head, every bar moves one cell down
    logic advance;  // the partial result moves one cell towards the head
  } swhl_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swhl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swhl_cell #(
  parameter int PRICE_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  swhl_pkg::swhl_ctrl_t         ctrl_i,
  input  wire                          inject_i,
  input  wire  signed [PRICE_BITS-1:0] bar_hi_i,
  input  wire  signed [PRICE_BITS-1:0] bar_lo_i,
  output logic signed [PRICE_BITS-1:0] bar_hi_o,
  output logic signed [PRICE_BITS-1:0] bar_lo_o,
  input  wire                          tok_vld_i,
  input  wire  signed [PRICE_BITS-1:0] tok_hi_i,
  input  wire  signed [PRICE_BITS-1:0] tok_lo_i,
  output logic                         tok_vld_o,
  output logic signed [PRICE_BITS-1:0] tok_hi_o,
  output logic signed [PRICE_BITS-1:0] tok_lo_o
);
  import swhl_pkg::*;

  localparam logic signed [PRICE_BITS-1:0] PRICE_MIN = {1'b1, {(PRICE_BITS-1){1'b0}}};
  localparam logic signed [PRICE_BITS-1:0] PRICE_MAX = {1'b0, {(PRICE_BITS-1){1'b1}}};

  logic signed [PRICE_BITS-1:0] bar_hi_q, bar_hi_d;
  logic signed [PRICE_BITS-1:0] bar_lo_q, bar_lo_d;
  logic                         tok_vld_q, tok_vld_d;
  logic signed [PRICE_BITS-1:0] tok_hi_q, tok_hi_d;
  logic signed [PRICE_BITS-1:0] tok_lo_q, tok_lo_d;
  logic signed [PRICE_BITS-1:0] in_hi, in_lo;
  logic                         tok_load;

  always_comb begin
    bar_hi_d = ctrl_i.shift ? bar_hi_i : bar_hi_q;
    bar_lo_d = ctrl_i.shift ? bar_lo_i : bar_lo_q;

    // the oldest cell of the window starts from the neutral pair
    in_hi = inject_i ? PRICE_MIN : tok_hi_i;
    in_lo = inject_i ? PRICE_MAX : tok_lo_i;

    tok_hi_d = (bar_hi_d > in_hi) ? bar_hi_d : in_hi;
    tok_lo_d = (bar_lo_d < in_lo) ? bar_lo_d : in_lo;

    tok_load  = inject_i || (ctrl_i.advance && tok_vld_i);
    tok_vld_d = tok_vld_q;
    if (inject_i) begin
      tok_vld_d = 1'b1;
    end else if (ctrl_i.advance) begin
      tok_vld_d = tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bar_hi_q <= bar_hi_d;
    bar_lo_q <= bar_lo_d;
    if (tok_load) begin
      tok_hi_q <= tok_hi_d;
      tok_lo_q <= tok_lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_d;
    end
  end

  assign bar_hi_o  = bar_hi_q;
  assign bar_lo_o  = bar_lo_q;
  assign tok_vld_o = tok_vld_q;
  assign tok_hi_o  = tok_hi_q;
  assign tok_lo_o  = tok_lo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_high_low_channel.sv -----
// Sliding-window high/low channel.
// Input channel: one bar per transaction (high_price_i, low_price_i, want_output_i,
// last_bar_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one result per transaction (upper, middle and lower band,
// bar index, series end), taken when out_valid_o is high and out_stall_i is low.
// Bars live in a row of WINDOW_MAX cells; a new bar enters at the head and every
// stored bar moves down by one cell. When a result is due, a partial max/min
// starts at cell len-1, which holds the oldest bar of the window, and walks back
// to the head, one cell per cycle, and then into the output register
// (len = effective window length, 1..WINDOW_MAX).
// Bars that give no result stream at one per cycle while no result is pending.
// A bar that gives a result holds in_stall_o high until the result is in the output
// register. The output register frees the chain, so the walk pauses only when a
// finished result meets a stalled, still full output register.
// Reset clears the window length to 20, the fill count, the bar counter and all
// valid flags; stored bars are undefined until written. A last bar clears fill
// count and bar counter when it is accepted.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_high_low_channel #(
  parameter int WINDOW_MAX = 64,
  parameter int PRICE_BITS = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [swhl_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [swhl_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [swhl_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // input channel
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  signed [PRICE_BITS-1:0]      high_price_i,
  input  wire  signed [PRICE_BITS-1:0]      low_price_i,
  input  wire                               want_output_i,
  input  wire                               last_bar_i,
  // output channel
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [PRICE_BITS-1:0]      upper_band_o,
  output logic signed [PRICE_BITS:0]        middle_band_o,
  output logic signed [PRICE_BITS-1:0]      lower_band_o,
  output logic [swhl_pkg::IDX_W-1:0]        bar_index_o,
  output logic                              series_end_o
);
  import swhl_pkg::*;

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (LEN_W > WL_W) ? LEN_W : WL_W;

  // configuration register
  logic [WL_W-1:0]      wl_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_WINDOW_LENGTH) begin
      prdata = {{(CFG_DATA_W-WL_W){1'b0}}, wl_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
    end else if (cfg_wr && (reg_idx == REG_WINDOW_LENGTH)) begin
      wl_q <= pwdata[WL_W-1:0];
    end
  end

  // effective window length, clamped to 1..WINDOW_MAX
  logic [CMP_W-1:0] wl_ext;
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    wl_ext = CMP_W'(wl_q);
    if (wl_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(wl_ext);
    end
  end

  // series control
  logic [LEN_W-1:0] fill_q, fill_next;
  logic [IDX_W-1:0] bar_cnt_q;
  logic             busy_q;
  logic [IDX_W-1:0] tok_idx_q;
  logic             tok_end_q;
  logic             in_acc, emit, start;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fill_next  = fill_q + LEN_W'(fill_q != LEN_W'(WINDOW_MAX));
  assign emit       = want_output_i && (fill_next >= eff_len);
  assign start      = in_acc && emit;

  // chain of cells
  logic signed [PRICE_BITS-1:0] bar_hi [WINDOW_MAX];
  logic signed [PRICE_BITS-1:0] bar_lo [WINDOW_MAX];
  logic                         tok_vld [WINDOW_MAX];
  logic signed [PRICE_BITS-1:0] tok_hi [WINDOW_MAX];
  logic signed [PRICE_BITS-1:0] tok_lo [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]        tok_vld_vec;
  swhl_ctrl_t                   ctrl;
  logic                         out_load;

  // head cell holds the finished result; it may only move on when the output can take it
  assign out_load     = tok_vld[0] && (!out_valid_o || !out_stall_i);
  assign ctrl.shift   = in_acc;
  assign ctrl.advance = !tok_vld[0] || out_load;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic                         inject;
    logic signed [PRICE_BITS-1:0] src_hi, src_lo;
    logic                         nxt_vld;
    logic signed [PRICE_BITS-1:0] nxt_hi, nxt_lo;

    assign inject = start && (eff_len == LEN_W'(k + 1));
    assign tok_vld_vec[k] = tok_vld[k];

    if (k == 0) begin : g_head
      assign src_hi = high_price_i;
      assign src_lo = low_price_i;
    end else begin : g_body
      assign src_hi = bar_hi[k-1];
      assign src_lo = bar_lo[k-1];
    end

    if (k == WINDOW_MAX - 1) begin : g_tail
      assign nxt_vld = 1'b0;
      assign nxt_hi  = '0;
      assign nxt_lo  = '0;
    end else begin : g_link
      assign nxt_vld = tok_vld[k+1];
      assign nxt_hi  = tok_hi[k+1];
      assign nxt_lo  = tok_lo[k+1];
    end

    swhl_cell #(
      .PRICE_BITS (PRICE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .inject_i  (inject),
      .bar_hi_i  (src_hi),
      .bar_lo_i  (src_lo),
      .bar_hi_o  (bar_hi[k]),
      .bar_lo_o  (bar_lo[k]),
      .tok_vld_i (nxt_vld),
      .tok_hi_i  (nxt_hi),
      .tok_lo_i  (nxt_lo),
      .tok_vld_o (tok_vld[k]),
      .tok_hi_o  (tok_hi[k]),
      .tok_lo_o  (tok_lo[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      bar_cnt_q <= '0;
      busy_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        if (last_bar_i) begin
          fill_q    <= '0;
          bar_cnt_q <= '0;
        end else begin
          fill_q <= fill_next;
          if (bar_cnt_q != '1) begin
            bar_cnt_q <= bar_cnt_q + IDX_W'(1);
          end
        end
      end
      if (start) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      tok_idx_q <= bar_cnt_q;
      tok_end_q <= last_bar_i;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      upper_band_o  <= tok_hi[0];
      lower_band_o  <= tok_lo[0];
      middle_band_o <= (PRICE_BITS+1)'(tok_hi[0]) + (PRICE_BITS+1)'(tok_lo[0]);
      bar_index_o   <= tok_idx_q;
      series_end_o  <= tok_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one partial result in the chain");

  a_token_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vld_vec != '0) |-> busy_q)
    else $error("partial result in the chain while input is open");

  a_start_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (busy_q && (tok_vld_vec != '0)))
    else $error("result walk did not start after an accepted bar");
`endif

endmodule

`default_nettype wire
